@@ src/edf_pkg.sv @@
// shared types and constants for the edf scheduler
package edf_pkg;

  localparam int QueueDepth = 16;
  localparam int SlotW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    EV_ACCEPT  = 3'd0,
    EV_REJECT  = 3'd1,
    EV_START   = 3'd2,
    EV_PREEMPT = 3'd3,
    EV_FINISH  = 3'd4
  } event_t;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;     // capture input item
    logic scan_clr;    // reset scan search
    logic scan_step;   // compare one slot
    logic do_arrive;   // store arrival in free slot
    logic do_sched;    // start or preempt and run one unit
    logic pop;         // advance result list
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic res_pending;
  } dp_sts_t;

endpackage

@@ src/edf_dpath.sv @@
// datapath: slot store, running job, time counter, result list
module edf_dpath import edf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts,
  input  logic [7:0]   in_job_id,
  input  logic [15:0]  in_exec_time,
  input  logic [15:0]  in_period,
  output logic [2:0]   out_event_res,
  output logic [7:0]   out_job_id_res,
  output logic [31:0]  out_event_time,
  output logic [15:0]  out_remaining,
  output logic         out_missed_deadline,
  output logic [31:0]  out_turnaround,
  output logic         out_last
);

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  job;
    logic [15:0] rem;
    logic        miss;
    logic [31:0] turn;
  } res_t;

  logic [QueueDepth-1:0] valid_r;
  logic [7:0]  sjob_r [QueueDepth];
  logic [31:0] sdl_r  [QueueDepth];
  logic [31:0] sarr_r [QueueDepth];
  logic [15:0] srem_r [QueueDepth];

  logic        run_v_r;
  logic [7:0]  run_job_r;
  logic [31:0] run_dl_r, run_arr_r;
  logic [15:0] run_rem_r;
  logic [31:0] time_r;

  logic [7:0]  job_r;
  logic [15:0] ex_r, per_r;

  logic [CntW-1:0]  scan_r;
  logic             best_v_r;
  logic [SlotW-1:0] best_r;
  logic             free_v_r;
  logic [SlotW-1:0] free_r;

  res_t       res_r [3];
  logic [1:0] rcnt_r, ridx_r;
  logic [31:0] rtime_r;

  function automatic logic earlier(input logic [31:0] d1, input logic [31:0] a1,
                                   input logic [31:0] d2, input logic [31:0] a2);
    earlier = (d1 < d2) || ((d1 == d2) && (a1 < a2));
  endfunction

  logic [SlotW-1:0] si;
  assign si = scan_r[SlotW-1:0];
  assign sts.scan_done = (scan_r == CntW'(QueueDepth));
  assign sts.res_pending = (ridx_r < rcnt_r);

  // arrival deadline with saturation
  logic [32:0] dl_sum;
  assign dl_sum = {1'b0, time_r} + {17'd0, per_r};
  logic [15:0] ex_eff;
  assign ex_eff = (ex_r == 16'd0) ? 16'd1 : ex_r;

  // preempt decision
  logic preempt;
  assign preempt = run_v_r && best_v_r &&
                   earlier(sdl_r[best_r], sarr_r[best_r], run_dl_r, run_arr_r);

  // input capture and slot scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      best_v_r <= 1'b0;
      free_v_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_r <= '0;
      best_v_r <= 1'b0;
      free_v_r <= 1'b0;
    end else if (cmd.scan_step && !sts.scan_done) begin
      scan_r <= scan_r + 1'b1;
      if (valid_r[si]) begin
        if (!best_v_r || earlier(sdl_r[si], sarr_r[si], sdl_r[best_r], sarr_r[best_r])) begin
          best_v_r <= 1'b1;
          best_r <= si;
        end
      end else if (!free_v_r) begin
        free_v_r <= 1'b1;
        free_r <= si;
      end
    end
    if (cmd.load_in) begin
      job_r <= in_job_id;
      ex_r <= in_exec_time;
      per_r <= in_period;
    end
  end

  // scheduler state update and result list
  logic [15:0] rem_new;
  logic [15:0] cur_rem;
  always_comb begin
    cur_rem = preempt ? srem_r[best_r] : ((!run_v_r && best_v_r) ? srem_r[best_r] : run_rem_r);
    rem_new = (cur_rem > 16'd0) ? cur_rem - 16'd1 : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      run_v_r <= 1'b0;
      run_job_r <= '0;
      run_dl_r <= '0;
      run_arr_r <= '0;
      run_rem_r <= '0;
      time_r <= '0;
      rcnt_r <= '0;
      ridx_r <= '0;
    end else begin
      if (cmd.pop) ridx_r <= ridx_r + 2'd1;
      if (cmd.do_arrive) begin
        rtime_r <= time_r;
        ridx_r <= '0;
        rcnt_r <= 2'd1;
        res_r[0] <= '{ev: free_v_r ? EV_ACCEPT : EV_REJECT, job: job_r, rem: ex_eff,
                      miss: 1'b0, turn: 32'd0};
        if (free_v_r) begin
          valid_r[free_r] <= 1'b1;
          sjob_r[free_r] <= job_r;
          sdl_r[free_r] <= dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
          sarr_r[free_r] <= time_r;
          srem_r[free_r] <= ex_eff;
        end
      end
      if (cmd.do_sched) begin : sched
        logic [1:0] n;
        logic       rv;
        logic [7:0] rj;
        logic [31:0] rd, ra;
        n = 2'd0;
        rv = run_v_r; rj = run_job_r; rd = run_dl_r; ra = run_arr_r;
        rtime_r <= time_r;
        ridx_r <= '0;
        if (!run_v_r && best_v_r) begin
          valid_r[best_r] <= 1'b0;
          rv = 1'b1; rj = sjob_r[best_r]; rd = sdl_r[best_r]; ra = sarr_r[best_r];
          res_r[0] <= '{ev: EV_START, job: rj, rem: srem_r[best_r], miss: 1'b0, turn: 32'd0};
          n = 2'd1;
        end else if (preempt) begin
          sjob_r[best_r] <= run_job_r;
          sdl_r[best_r] <= run_dl_r;
          sarr_r[best_r] <= run_arr_r;
          srem_r[best_r] <= run_rem_r;
          res_r[0] <= '{ev: EV_PREEMPT, job: run_job_r, rem: run_rem_r, miss: 1'b0,
                        turn: 32'd0};
          rj = sjob_r[best_r]; rd = sdl_r[best_r]; ra = sarr_r[best_r];
          res_r[1] <= '{ev: EV_START, job: rj, rem: srem_r[best_r], miss: 1'b0, turn: 32'd0};
          n = 2'd2;
        end
        if (rv) begin
          if (rem_new == 16'd0) begin
            res_r[n] <= '{ev: EV_FINISH, job: rj, rem: 16'd0, miss: time_r >= rd,
                          turn: time_r - ra};
            n = n + 2'd1;
            rv = 1'b0;
          end
        end
        run_v_r <= rv; run_job_r <= rj; run_dl_r <= rd; run_arr_r <= ra;
        run_rem_r <= rem_new;
        rcnt_r <= n;
        if (time_r != 32'hFFFF_FFFF) time_r <= time_r + 32'd1;
      end
    end
  end

  // result item view
  res_t cur;
  assign cur = res_r[ridx_r];
  assign out_event_res = cur.ev;
  assign out_job_id_res = cur.job;
  assign out_event_time = rtime_r;
  assign out_remaining = cur.rem;
  assign out_missed_deadline = cur.miss;
  assign out_turnaround = cur.turn;
  assign out_last = (ridx_r + 2'd1 == rcnt_r);

endmodule

@@ src/edf_ctrl.sv @@
// controller: sequences capture, scan, update and result delivery
module edf_ctrl import edf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    in_opcode,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   op_r, op_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT) && sts.res_pending;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.scan_clr = 1'b1;
          op_nxt = in_opcode;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (op_r == OP_ARRIVE) cmd.do_arrive = 1'b1;
        else cmd.do_sched = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.res_pending) state_nxt = S_IDLE;
        else if (!out_stall) cmd.pop = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= OP_ARRIVE;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end

endmodule

@@ src/edf_preemptive_scheduler.sv @@
// top level of the earliest-deadline-first scheduler
//   channel  direction  handshake        payload
//   in_      input      in_valid/stall   opcode, job_id, exec_time, period
//   out_     output     out_valid/stall  event_res .. last
// An item passes through capture, a scan of the 16 slots and a done check, one
// update, the delivery of each result in turn and a return to idle. The slot
// scan walks one slot a cycle through one deadline comparator.
// Reset is synchronous, active low, and empties the store.
// Output stall holds the current result; no input is taken until all go.
module edf_preemptive_scheduler import edf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_job_id,
  input  logic [15:0] in_exec_time,
  input  logic [15:0] in_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_job_id_res,
  output logic [31:0] out_event_time,
  output logic [15:0] out_remaining,
  output logic        out_missed_deadline,
  output logic [31:0] out_turnaround,
  output logic        out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  edf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .out_valid, .out_stall,
    .cmd, .sts
  );

  edf_dpath u_dpath (
    .clk, .rst_n, .cmd, .sts, .in_job_id, .in_exec_time, .in_period,
    .out_event_res, .out_job_id_res, .out_event_time, .out_remaining,
    .out_missed_deadline, .out_turnaround, .out_last
  );

`ifndef NO_ASSERTIONS
  // no result offered while an item is being taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("result and input overlap");
  // finish carries zero remaining
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_FINISH) |-> (out_remaining == 16'd0))
    else $error("finish with work left");
  // accept always followed by stall
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("input not held off");
`endif

endmodule
